>>> hw/rtl/q2e_pkg.sv
// Shared types, constants and helper functions of the quaternion to Euler angle block.
package q2e_pkg;

  localparam int IN_W    = 16;
  localparam int PROD_W  = 32;
  localparam int TERM_W  = 35;
  localparam int T2_W    = 30;
  localparam int SQ_W    = 59;
  localparam int ROOT_W  = 29;
  localparam int CORD_W  = 38;
  localparam int ANG_W   = 34;
  localparam int OUT_W   = 16;
  localparam int TAB_LEN = 24;
  localparam int SQ_DLY  = 2 + ROOT_W;

  localparam logic signed [TERM_W-1:0] ONE_Q28     = 35'sd268435456;
  localparam logic signed [ANG_W-1:0]  HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [OUT_W-1:0]  ANGLE_MAX   = 16'sd25736;

  typedef struct packed {
    logic signed [IN_W-1:0] q_scalar;
    logic signed [IN_W-1:0] q_x;
    logic signed [IN_W-1:0] q_y;
    logic signed [IN_W-1:0] q_z;
  } q2e_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] pitch_angle;
    logic signed [OUT_W-1:0] roll_angle;
    logic signed [OUT_W-1:0] yaw_angle;
  } q2e_res_t;

  typedef struct packed {
    logic signed [CORD_W-1:0] x;
    logic signed [CORD_W-1:0] y;
    logic signed [ANG_W-1:0]  z;
    logic                     zero;
  } q2e_cordic_t;

  typedef struct packed {
    logic [SQ_W-1:0]   rem;
    logic [ROOT_W-1:0] root;
  } q2e_sqrt_t;

  // Number of CORDIC iterations actually built.
  function automatic int cordic_iters(input int steps);
    return (steps < TAB_LEN) ? steps : TAB_LEN;
  endfunction

  // Depth of the valid pipeline from an accepted beat to its result strobe.
  function automatic int q2e_latency(input int steps);
    return 2 + SQ_DLY + 1 + cordic_iters(steps) + 1;
  endfunction

  // atan(2^-i) in units of 2^-30 rad, truncated.
  function automatic logic signed [ANG_W-1:0] atan_entry(input int i);
    logic signed [ANG_W-1:0] v;
    case (i)
      0:       v = 34'sh03243F6A8;
      1:       v = 34'sh01DAC6705;
      2:       v = 34'sh00FADBAFC;
      3:       v = 34'sh007F56EA6;
      4:       v = 34'sh003FEAB76;
      5:       v = 34'sh001FFD55B;
      6:       v = 34'sh000FFFAAA;
      7:       v = 34'sh0007FFF55;
      8:       v = 34'sh0003FFFEA;
      9:       v = 34'sh0001FFFFD;
      10:      v = 34'sh0000FFFFF;
      11:      v = 34'sh00007FFFF;
      12:      v = 34'sh00003FFFF;
      13:      v = 34'sh00001FFFF;
      14:      v = 34'sh00000FFFF;
      15:      v = 34'sh000007FFF;
      16:      v = 34'sh000003FFF;
      17:      v = 34'sh000001FFF;
      18:      v = 34'sh000000FFF;
      19:      v = 34'sh0000007FF;
      20:      v = 34'sh0000003FF;
      21:      v = 34'sh0000001FF;
      22:      v = 34'sh0000000FF;
      23:      v = 34'sh00000007F;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Zero detection and quarter turn into the right half plane.
  function automatic q2e_cordic_t cordic_pre(input logic signed [CORD_W-1:0] y,
                                             input logic signed [CORD_W-1:0] x);
    q2e_cordic_t c;
    c.zero = (x == '0) && (y == '0);
    c.x = x;
    c.y = y;
    c.z = '0;
    if (x < 0) begin
      if (y >= 0) begin
        c.x = y;
        c.y = -x;
        c.z = HALF_PI_Q30;
      end else begin
        c.x = -y;
        c.y = x;
        c.z = -HALF_PI_Q30;
      end
    end
    return c;
  endfunction

  // Round half up to Q2.13 and saturate.
  function automatic logic signed [OUT_W-1:0] to_q213(input q2e_cordic_t c);
    logic signed [ANG_W-1:0]    r;
    logic signed [ANG_W-18:0]   a;
    logic signed [OUT_W-1:0]    o;
    r = c.z + ANG_W'(65536);
    a = (ANG_W-17)'(r >>> 17);
    if (c.zero) begin
      o = '0;
    end else if (a > (ANG_W-17)'(ANGLE_MAX)) begin
      o = ANGLE_MAX;
    end else if (a < -(ANG_W-17)'(ANGLE_MAX)) begin
      o = -ANGLE_MAX;
    end else begin
      o = OUT_W'(a);
    end
    return o;
  endfunction

endpackage

>>> hw/rtl/quaternion_to_euler.sv
// Top level: attitude quaternion in, pitch, roll and yaw angles out.
//
// Usage. A quaternion beat (scalar and vector parts, signed Q1.14) is taken
// on in_i at every rising edge at which start is high and busy is low. busy
// is held low at all times, so a new beat may be offered in every cycle.
// Each beat yields exactly one result beat on res_o (pitch, roll and yaw in
// radians, signed Q2.13), flagged by valid_o for a single cycle.
//
// Throughput is one beat per cycle. The latency is set by the pitch path:
// a product stage and a term stage, a squaring stage and a stage for one
// minus that square, one cell per root bit of the 29-bit square root, a
// quarter turn stage, one cell per CORDIC iteration and a rounding stage.
// Roll and yaw run through their own CORDIC chains straight away and are
// then held in a delay line so that all three angles leave together.
//
// Reset clears only the valid pipeline; beats in flight are dropped and no
// strobe follows a reset until new beats are accepted. The receiver cannot
// stall the block: results are presented for one cycle only.
module quaternion_to_euler #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  q2e_pkg::q2e_in_t  in_i,
  output logic              valid_o,
  output q2e_pkg::q2e_res_t res_o
);
  import q2e_pkg::*;

  localparam int N   = cordic_iters(CORDIC_STEPS);
  localparam int LAT = q2e_latency(CORDIC_STEPS);

  // The pipeline never stalls, so a beat is accepted whenever start is high.
  assign busy = 1'b0;

  // Stage one: the nine pairwise products.
  logic signed [PROD_W-1:0] cc_q, dd_q, bc_q, ad_q, bd_q, ac_q, cd_q, ab_q, bb_q;

  always_ff @(posedge clk_i) begin
    cc_q <= in_i.q_y * in_i.q_y;
    dd_q <= in_i.q_z * in_i.q_z;
    bc_q <= in_i.q_x * in_i.q_y;
    ad_q <= in_i.q_scalar * in_i.q_z;
    bd_q <= in_i.q_x * in_i.q_z;
    ac_q <= in_i.q_scalar * in_i.q_y;
    cd_q <= in_i.q_y * in_i.q_z;
    ab_q <= in_i.q_scalar * in_i.q_x;
    bb_q <= in_i.q_x * in_i.q_x;
  end

  // Stage two: the rotation-matrix terms, with the pitch term clamped to
  // the range of plus to minus one.
  logic signed [TERM_W-1:0] t0_q, t1_q, t3_q, t4_q, t2_raw;
  logic signed [T2_W-1:0]   t2c_q, t2c_d;

  always_comb begin
    t2_raw = (TERM_W'(ac_q) - TERM_W'(bd_q)) <<< 1;
    if (t2_raw > ONE_Q28) begin
      t2c_d = T2_W'(ONE_Q28);
    end else if (t2_raw < -ONE_Q28) begin
      t2c_d = T2_W'(-ONE_Q28);
    end else begin
      t2c_d = T2_W'(t2_raw);
    end
  end

  always_ff @(posedge clk_i) begin
    t0_q  <= ONE_Q28 - ((TERM_W'(cc_q) + TERM_W'(dd_q)) <<< 1);
    t1_q  <= (TERM_W'(bc_q) + TERM_W'(ad_q)) <<< 1;
    t3_q  <= (TERM_W'(cd_q) + TERM_W'(ab_q)) <<< 1;
    t4_q  <= ONE_Q28 - ((TERM_W'(bb_q) + TERM_W'(cc_q)) <<< 1);
    t2c_q <= t2c_d;
  end

  // Pitch path: square of the clamped term, then one minus that square.
  logic signed [2*T2_W-1:0] t2sq_full;
  logic [SQ_W-1:0]          t2sq_q, sq_q;

  assign t2sq_full = t2c_q * t2c_q;

  always_ff @(posedge clk_i) begin
    t2sq_q <= SQ_W'(t2sq_full);
    sq_q   <= (SQ_W'(1) << 56) - t2sq_q;
  end

  // The square root chain works on one root bit per cell, top bit first.
  q2e_sqrt_t sq_s [ROOT_W+1];

  assign sq_s[0].rem  = sq_q;
  assign sq_s[0].root = '0;

  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
    q2e_sqrt_cell #(.K(ROOT_W - 1 - j)) u_cell (
      .clk_i (clk_i),
      .s_i   (sq_s[j]),
      .s_o   (sq_s[j+1])
    );
  end

  // The clamped pitch term waits alongside the square root.
  logic signed [T2_W-1:0] t2_dly_q [SQ_DLY];

  always_ff @(posedge clk_i) begin
    t2_dly_q[0] <= t2c_q;
    for (int k = 1; k < SQ_DLY; k++) begin
      t2_dly_q[k] <= t2_dly_q[k-1];
    end
  end

  // Three CORDIC chains, each starting with a registered quarter turn.
  q2e_cordic_t pc [N+1];
  q2e_cordic_t rc [N+1];
  q2e_cordic_t yc [N+1];

  always_ff @(posedge clk_i) begin
    pc[0] <= cordic_pre(CORD_W'(t2_dly_q[SQ_DLY-1]),
                        CORD_W'({1'b0, sq_s[ROOT_W].root}));
    rc[0] <= cordic_pre(CORD_W'(t3_q), CORD_W'(t4_q));
    yc[0] <= cordic_pre(CORD_W'(t1_q), CORD_W'(t0_q));
  end

  for (genvar i = 0; i < N; i++) begin : g_cordic
    q2e_cordic_cell #(.I(i)) u_pitch (.clk_i(clk_i), .c_i(pc[i]), .c_o(pc[i+1]));
    q2e_cordic_cell #(.I(i)) u_roll  (.clk_i(clk_i), .c_i(rc[i]), .c_o(rc[i+1]));
    q2e_cordic_cell #(.I(i)) u_yaw   (.clk_i(clk_i), .c_i(yc[i]), .c_o(yc[i+1]));
  end

  // Rounding; roll and yaw are then delayed to meet the pitch result.
  logic signed [OUT_W-1:0] pitch_q;
  logic signed [OUT_W-1:0] roll_dly_q [SQ_DLY+1];
  logic signed [OUT_W-1:0] yaw_dly_q  [SQ_DLY+1];

  always_ff @(posedge clk_i) begin
    pitch_q       <= to_q213(pc[N]);
    roll_dly_q[0] <= to_q213(rc[N]);
    yaw_dly_q[0]  <= to_q213(yc[N]);
    for (int k = 1; k <= SQ_DLY; k++) begin
      roll_dly_q[k] <= roll_dly_q[k-1];
      yaw_dly_q[k]  <= yaw_dly_q[k-1];
    end
  end

  // Valid bits follow each beat through the whole pipeline.
  logic [LAT-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], start};
    end
  end

  assign valid_o           = vld_q[LAT-1];
  assign res_o.pitch_angle = pitch_q;
  assign res_o.roll_angle  = roll_dly_q[SQ_DLY];
  assign res_o.yaw_angle   = yaw_dly_q[SQ_DLY];

endmodule

>>> hw/rtl/q2e_sqrt_cell.sv
// One bit of the pipelined integer square root.
module q2e_sqrt_cell #(
  parameter int K = 0
) (
  input  logic               clk_i,
  input  q2e_pkg::q2e_sqrt_t s_i,
  output q2e_pkg::q2e_sqrt_t s_o
);
  import q2e_pkg::*;

  logic [SQ_W-1:0] trial;
  q2e_sqrt_t       s_d, s_q;

  always_comb begin
    trial = (SQ_W'(s_i.root) << (K + 1)) + (SQ_W'(1) << (2 * K));
    s_d = s_i;
    if (s_i.rem >= trial) begin
      s_d.rem  = s_i.rem - trial;
      s_d.root = s_i.root | (ROOT_W'(1) << K);
    end
  end

  always_ff @(posedge clk_i) begin
    s_q <= s_d;
  end

  assign s_o = s_q;
endmodule

>>> hw/rtl/q2e_cordic_cell.sv
// One vectoring iteration of the CORDIC chain.
module q2e_cordic_cell #(
  parameter int I = 0
) (
  input  logic                 clk_i,
  input  q2e_pkg::q2e_cordic_t c_i,
  output q2e_pkg::q2e_cordic_t c_o
);
  import q2e_pkg::*;

  logic signed [CORD_W-1:0] xs, ys;
  q2e_cordic_t              c_d, c_q;

  always_comb begin
    xs = c_i.x >>> I;
    ys = c_i.y >>> I;
    c_d = c_i;
    if (c_i.y > 0) begin
      c_d.x = c_i.x + ys;
      c_d.y = c_i.y - xs;
      c_d.z = c_i.z + atan_entry(I);
    end else begin
      c_d.x = c_i.x - ys;
      c_d.y = c_i.y + xs;
      c_d.z = c_i.z - atan_entry(I);
    end
  end

  always_ff @(posedge clk_i) begin
    c_q <= c_d;
  end

  assign c_o = c_q;
endmodule

>>> hw/rtl/q2e_checker.sv
// Port-level assertions for the quaternion to Euler angle block, with its bind.
module q2e_checker #(
  parameter int CORDIC_STEPS = 16
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input q2e_pkg::q2e_in_t  in_i,
  input logic              valid_o,
  input q2e_pkg::q2e_res_t res_o
);
  import q2e_pkg::*;

  localparam int LAT = q2e_latency(CORDIC_STEPS);

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start, LAT))
    else $error("result without an accepted beat");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (res_o.pitch_angle <= ANGLE_MAX && res_o.pitch_angle >= -ANGLE_MAX &&
                 res_o.roll_angle  <= ANGLE_MAX && res_o.roll_angle  >= -ANGLE_MAX &&
                 res_o.yaw_angle   <= ANGLE_MAX && res_o.yaw_angle   >= -ANGLE_MAX))
    else $error("angle out of range");

  a_zero_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && $past(in_i, LAT) == '0) |-> (res_o == '0))
    else $error("zero quaternion gave non-zero angles");

endmodule

bind quaternion_to_euler q2e_checker #(.CORDIC_STEPS(CORDIC_STEPS)) u_q2e_checker (.*);
